/* hdl/pbl_pkg.sv */
// ----------------------------------------------------------------------------
// pbl_pkg
// Shared widths, codes and handshake types of the pairwise bit-linkage block.
// ----------------------------------------------------------------------------
package pbl_pkg;

  localparam int LOCI_DEF     = 64;
  localparam int MAX_ROWS_DEF = 1024;
  localparam int FRAC_DEF     = 16;

  localparam int ROW_W  = 64;
  localparam int LOC_W  = 6;
  localparam int CNT_W  = 11;
  localparam int OUT_W  = 24;
  localparam int LOG_W  = 33;
  localparam int DIFF_W = 36;
  localparam int SUM_W  = 50;
  localparam int DEN_W  = 33;
  localparam int NLOGS  = 9;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SAME  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [ROW_W-1:0] row;
    logic [LOC_W-1:0] a;
    logic [LOC_W-1:0] b;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] value;
  } log_req_t;

  typedef struct packed {
    logic             done;
    logic [LOG_W-1:0] value;
  } log_rsp_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] sum;
    logic [DEN_W-1:0]        den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [OUT_W-1:0] value;
  } div_rsp_t;

endpackage

/* hdl/pbl_ram.sv */
// ----------------------------------------------------------------------------
// pbl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/pbl_front.sv */
// ----------------------------------------------------------------------------
// pbl_front
// Input side: classify items, drop unused kinds, hold two in a queue.
// ----------------------------------------------------------------------------
module pbl_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                kind,
  input  logic [pbl_pkg::ROW_W-1:0] row_bits,
  input  logic [pbl_pkg::LOC_W-1:0] locus_a,
  input  logic [pbl_pkg::LOC_W-1:0] locus_b,
  input  logic                      hold,
  output logic                      q_valid,
  output pbl_pkg::item_t            q_item,
  input  logic                      q_pop
);

  pbl_pkg::item_t slot [2];
  pbl_pkg::item_t item;
  logic [1:0]     count;
  logic           head;
  logic           known;
  logic           push;
  logic           pop;
  logic           tail;

  always_comb begin
    known   = 1'b1;
    item.op = pbl_pkg::OP_CLEAR;
    unique case (kind)
      pbl_pkg::KIND_CLEAR: item.op = pbl_pkg::OP_CLEAR;
      pbl_pkg::KIND_LOAD:  item.op = pbl_pkg::OP_LOAD;
      pbl_pkg::KIND_QUERY: item.op = pbl_pkg::OP_QUERY;
      default:             known   = 1'b0;
    endcase
    item.row = row_bits;
    item.a   = locus_a;
    item.b   = locus_b;
  end

  assign in_stall = hold || (count == 2'd2);
  assign push     = in_valid && !in_stall && known;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_pop && q_valid;
  assign tail     = head ^ count[0];
  assign q_item   = slot[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      head  <= 1'b0;
    end else begin
      head  <= head ^ pop;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[tail] <= item;
    end
  end

endmodule

/* hdl/pbl_log.sv */
// ----------------------------------------------------------------------------
// pbl_log
// Iterative natural log of an 11-bit count in Q30, one squaring per cycle.
// ----------------------------------------------------------------------------
module pbl_log (
  input  logic              clk,
  input  logic              rst,
  input  pbl_pkg::log_req_t req,
  output pbl_pkg::log_rsp_t rsp
);

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_SQ   = 4'b0010,
    L_MUL  = 4'b0100,
    L_FIN  = 4'b1000
  } lstate_t;

  lstate_t     state;
  logic [30:0] m;
  logic [29:0] frac;
  logic [3:0]  e;
  logic [3:0]  e_c;
  logic [4:0]  step;
  logic        zero;
  logic [59:0] prod;
  logic [61:0] sq;
  logic [31:0] sq_top;
  logic [59:0] prod_rnd;

  always_comb begin
    e_c = 4'd0;
    for (int b = 0; b < pbl_pkg::CNT_W; b++) begin
      if (req.value[b]) begin
        e_c = 4'(b);
      end
    end
    sq       = {31'b0, m} * {31'b0, m};
    sq_top   = sq[61:30];
    prod_rnd = (prod + (60'd1 << 29)) >> 30;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= L_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (state == L_FIN);
      unique case (state)
        L_IDLE: begin
          if (req.start) begin
            e     <= e_c;
            m     <= 31'(req.value) << (5'd30 - {1'b0, e_c});
            frac  <= '0;
            step  <= 5'd0;
            zero  <= (req.value == '0);
            state <= L_SQ;
          end
        end
        L_SQ: begin
          if (sq_top[31]) begin
            m                   <= sq_top[31:1];
            frac[5'd29 - step] <= 1'b1;
          end else begin
            m <= sq_top[30:0];
          end
          step <= step + 5'd1;
          if (step == 5'd29) begin
            state <= L_MUL;
          end
        end
        L_MUL: begin
          prod  <= {30'b0, frac} * {30'b0, pbl_pkg::LN2_Q30};
          state <= L_FIN;
        end
        L_FIN: begin
          rsp.value <= zero ? '0 :
                       pbl_pkg::LOG_W'(e) * pbl_pkg::LOG_W'(pbl_pkg::LN2_Q30)
                       + pbl_pkg::LOG_W'(prod_rnd);
          state     <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

/* hdl/pbl_div.sv */
// ----------------------------------------------------------------------------
// pbl_div
// Signed sum over denominator, rounded half away from zero, saturated to
// 24 bits; restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pbl_div (
  input  logic              clk,
  input  logic              rst,
  input  pbl_pkg::div_req_t req,
  output pbl_pkg::div_rsp_t rsp
);

  localparam int XW = pbl_pkg::SUM_W + 1;
  localparam int DW = pbl_pkg::DEN_W;

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_FIN  = 3'b100
  } dstate_t;

  dstate_t                     state;
  logic                        neg;
  logic [XW-1:0]               x;
  logic [XW-1:0]               q;
  logic [DW-1:0]               den_r;
  logic [DW-1:0]               rem;
  logic [5:0]                  step;
  logic [pbl_pkg::SUM_W-1:0]   mag;
  logic [DW:0]                 rsh;
  logic                        ge;

  always_comb begin
    mag = req.sum[pbl_pkg::SUM_W-1] ? pbl_pkg::SUM_W'(-req.sum)
                                    : pbl_pkg::SUM_W'(req.sum);
    rsh = {rem, x[XW-1]};
    ge  = (rsh >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= D_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (state == D_FIN);
      unique case (state)
        D_IDLE: begin
          if (req.start) begin
            neg   <= req.sum[pbl_pkg::SUM_W-1];
            x     <= {1'b0, mag} + XW'(req.den >> 1);
            den_r <= req.den;
            rem   <= '0;
            q     <= '0;
            step  <= 6'd0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem   <= ge ? DW'(rsh - {1'b0, den_r}) : rsh[DW-1:0];
          q     <= {q[XW-2:0], ge};
          x     <= x << 1;
          step  <= step + 6'd1;
          if (step == 6'(XW - 1)) begin
            state <= D_FIN;
          end
        end
        D_FIN: begin
          if (neg) begin
            rsp.value <= (q > XW'(1 << 23)) ? 24'h800000 : 24'(-q[23:0]);
          end else begin
            rsp.value <= (q > XW'((1 << 23) - 1)) ? 24'h7FFFFF : q[23:0];
          end
          state    <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

/* hdl/pbl_back.sv */
// ----------------------------------------------------------------------------
// pbl_back
// Execution side: clearing sweep, row load over the count stores, query
// sequencing through the shared log and divide units, output register.
// ----------------------------------------------------------------------------
module pbl_back #(
  parameter int LOCI      = pbl_pkg::LOCI_DEF,
  parameter int MAX_ROWS  = pbl_pkg::MAX_ROWS_DEF,
  parameter int FRAC_BITS = pbl_pkg::FRAC_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      mode,
  input  logic                      q_valid,
  input  pbl_pkg::item_t            q_item,
  output logic                      q_pop,
  output logic                      init_busy,
  output pbl_pkg::log_req_t         log_req,
  input  pbl_pkg::log_rsp_t         log_rsp,
  output pbl_pkg::div_req_t         div_req,
  input  pbl_pkg::div_rsp_t         div_rsp,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [pbl_pkg::OUT_W-1:0] link_same,
  output logic [pbl_pkg::OUT_W-1:0] link_diff,
  output logic [pbl_pkg::OUT_W-1:0] mutual_info,
  output logic [1:0]                status
);

  localparam int PAIRS = LOCI * (LOCI - 1) / 2;
  localparam int PA_W  = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int LA_W  = $clog2(LOCI);
  localparam int SWEEP = (PAIRS > LOCI) ? PAIRS : LOCI;
  localparam int SW_W  = $clog2(SWEEP);
  localparam int CW    = pbl_pkg::CNT_W;
  localparam int OW    = pbl_pkg::OUT_W;
  localparam int LW    = pbl_pkg::LOG_W;
  localparam int DFW   = pbl_pkg::DIFF_W;
  localparam int SW    = pbl_pkg::SUM_W;

  typedef enum logic [16:0] {
    B_CLR  = 17'h00001,
    B_IDLE = 17'h00002,
    B_LD1  = 17'h00004,
    B_LDP  = 17'h00008,
    B_LDE  = 17'h00010,
    B_Q0   = 17'h00020,
    B_Q1   = 17'h00040,
    B_Q2   = 17'h00080,
    B_Q3   = 17'h00100,
    B_LOG  = 17'h00200,
    B_LOGW = 17'h00400,
    B_DIFF = 17'h00800,
    B_MUL  = 17'h01000,
    B_ACC  = 17'h02000,
    B_DIV  = 17'h04000,
    B_DIVW = 17'h08000,
    B_OUT  = 17'h10000
  } bstate_t;

  bstate_t                 state;
  logic [SW_W-1:0]         sweep;
  logic [CW-1:0]           rows;
  logic [pbl_pkg::ROW_W-1:0] row;
  logic [pbl_pkg::LOC_W-1:0] lo;
  logic [pbl_pkg::LOC_W-1:0] hi;
  logic                    same;
  logic [LA_W-1:0]         k;
  logic [LA_W-1:0]         pi;
  logic [LA_W-1:0]         pj;
  logic [PA_W-1:0]         pp;
  logic                    ow_v;
  logic [LA_W-1:0]         ow_addr;
  logic                    pw_v;
  logic [PA_W-1:0]         pw_addr;
  logic [CW-1:0]           na;
  logic [CW-1:0]           nb;
  logic [CW-1:0]           n11r;
  logic [CW-1:0]           vals [pbl_pkg::NLOGS];
  logic [LW-1:0]           lg   [pbl_pkg::NLOGS];
  logic [3:0]              li;
  logic signed [DFW-1:0]   d    [4];
  logic                    tv   [4];
  logic [1:0]              ti;
  logic signed [SW-1:0]    prod;
  logic signed [SW-1:0]    s_same;
  logic signed [SW-1:0]    s_diff;
  logic [1:0]              di;
  logic [OW-1:0]           r_same;
  logic [OW-1:0]           r_diff;
  logic [OW-1:0]           r_mi;
  logic [1:0]              r_status;

  logic                    one_we;
  logic [LA_W-1:0]         one_waddr;
  logic [CW-1:0]           one_wdata;
  logic [LA_W-1:0]         one_raddr;
  logic [CW-1:0]           one_rd;
  logic                    pair_we;
  logic [PA_W-1:0]         pair_waddr;
  logic [CW-1:0]           pair_wdata;
  logic [PA_W-1:0]         pair_raddr;
  logic [CW-1:0]           pair_rd;

  logic [13:0]             sl_mul;
  logic [13:0]             slot;
  logic                    lo_in;
  logic                    hi_in;
  logic [CW-1:0]           n11;
  logic [CW:0]             na_n01;
  logic [CW-1:0]           n01;
  logic [CW-1:0]           n10;
  logic [CW-1:0]           n00;
  logic [CW-1:0]           t_n;
  logic signed [47:0]      mp;
  logic                    load_out;

  pbl_ram #(.WIDTH(CW), .DEPTH(LOCI)) u_ones (
    .clk   (clk),
    .we    (one_we),
    .waddr (one_waddr),
    .wdata (one_wdata),
    .raddr (one_raddr),
    .rdata (one_rd)
  );

  pbl_ram #(.WIDTH(CW), .DEPTH(PAIRS)) u_pairs (
    .clk   (clk),
    .we    (pair_we),
    .waddr (pair_waddr),
    .wdata (pair_wdata),
    .raddr (pair_raddr),
    .rdata (pair_rd)
  );

  always_comb begin
    sl_mul = 14'(lo) * (14'(2 * LOCI - 1) - 14'(lo));
    slot   = (sl_mul >> 1) + 14'(hi) - 14'(lo) - 14'd1;
    lo_in  = ({1'b0, lo} < 7'(LOCI));
    hi_in  = ({1'b0, hi} < 7'(LOCI));

    one_we     = ((state == B_CLR) && (SW_W'(LOCI - 1) >= sweep)) || ow_v;
    one_waddr  = (state == B_CLR) ? sweep[LA_W-1:0] : ow_addr;
    one_wdata  = (state == B_CLR) ? '0 : CW'(one_rd + 1'b1);
    pair_we    = ((state == B_CLR) && (SW_W'(PAIRS - 1) >= sweep)) || pw_v;
    pair_waddr = (state == B_CLR) ? sweep[PA_W-1:0] : pw_addr;
    pair_wdata = (state == B_CLR) ? '0 : CW'(pair_rd + 1'b1);

    one_raddr = k;
    if (state == B_Q0) begin
      one_raddr = lo[LA_W-1:0];
    end else if (state == B_Q1) begin
      one_raddr = hi[LA_W-1:0];
    end
    pair_raddr = (state == B_Q0) ? slot[PA_W-1:0] : pp;

    n11 = n11r;
    if (n11 > na) n11 = na;
    if (n11 > nb) n11 = nb;
    n10    = na - n11;
    n01    = nb - n11;
    na_n01 = {1'b0, na} + {1'b0, n01};
    n00    = ({1'b0, rows} >= na_n01) ? CW'({1'b0, rows} - na_n01) : '0;

    case (ti)
      2'd0:    t_n = vals[0];
      2'd1:    t_n = vals[3];
      2'd2:    t_n = vals[1];
      default: t_n = vals[2];
    endcase
    mp = $signed({1'b0, t_n}) * d[ti];

    q_pop     = (state == B_IDLE) && q_valid;
    init_busy = (state == B_CLR);
    load_out  = (state == B_OUT) && (!out_valid || !out_stall);

    log_req.start = (state == B_LOG);
    log_req.value = vals[li];
    div_req.start = (state == B_DIV);
    case (di)
      2'd0:    div_req.sum = s_same + s_diff;
      2'd1:    div_req.sum = s_same;
      default: div_req.sum = s_diff;
    endcase
    div_req.den = pbl_pkg::DEN_W'(rows) << (30 - FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLR;
      sweep     <= '0;
      rows      <= '0;
      ow_v      <= 1'b0;
      pw_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      ow_v <= (state == B_LD1) && row[k];
      pw_v <= (state == B_LDP) && row[pi] && row[pj];
      if (out_valid && !out_stall && !load_out) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_CLR: begin
          sweep <= sweep + 1'b1;
          if (sweep == SW_W'(SWEEP - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (q_valid) begin
            unique case (q_item.op)
              pbl_pkg::OP_CLEAR: begin
                sweep <= '0;
                rows  <= '0;
                state <= B_CLR;
              end
              pbl_pkg::OP_LOAD: begin
                if (rows != CW'(MAX_ROWS)) begin
                  rows  <= rows + 1'b1;
                  row   <= q_item.row;
                  k     <= '0;
                  state <= B_LD1;
                end
              end
              pbl_pkg::OP_QUERY: begin
                lo    <= (q_item.a < q_item.b) ? q_item.a : q_item.b;
                hi    <= (q_item.a < q_item.b) ? q_item.b : q_item.a;
                same  <= (q_item.a == q_item.b);
                state <= B_Q0;
              end
              default: state <= B_IDLE;
            endcase
          end
        end
        B_LD1: begin
          ow_addr <= k;
          if (k == LA_W'(LOCI - 1)) begin
            pi    <= '0;
            pj    <= LA_W'(1);
            pp    <= '0;
            state <= B_LDP;
          end else begin
            k <= k + 1'b1;
          end
        end
        B_LDP: begin
          pw_addr <= pp;
          pp      <= pp + 1'b1;
          if (pj == LA_W'(LOCI - 1)) begin
            if (pi == LA_W'(LOCI - 2)) begin
              state <= B_LDE;
            end else begin
              pi <= pi + 1'b1;
              pj <= pi + LA_W'(2);
            end
          end else begin
            pj <= pj + 1'b1;
          end
        end
        B_LDE: state <= B_IDLE;
        B_Q0: begin
          r_same <= '0;
          r_diff <= '0;
          r_mi   <= '0;
          if (same) begin
            r_status <= pbl_pkg::ST_SAME;
            state    <= B_OUT;
          end else if (rows == '0) begin
            r_status <= pbl_pkg::ST_EMPTY;
            state    <= B_OUT;
          end else begin
            r_status <= pbl_pkg::ST_OK;
            state    <= B_Q1;
          end
        end
        B_Q1: begin
          na    <= lo_in ? one_rd : '0;
          n11r  <= hi_in ? pair_rd : '0;
          state <= B_Q2;
        end
        B_Q2: begin
          nb    <= hi_in ? one_rd : '0;
          state <= B_Q3;
        end
        B_Q3: begin
          vals[0] <= n00;
          vals[1] <= n01;
          vals[2] <= n10;
          vals[3] <= n11;
          vals[4] <= na;
          vals[5] <= rows - na;
          vals[6] <= nb;
          vals[7] <= rows - nb;
          vals[8] <= rows;
          li      <= 4'd0;
          state   <= B_LOG;
        end
        B_LOG: state <= B_LOGW;
        B_LOGW: begin
          if (log_rsp.done) begin
            lg[li] <= log_rsp.value;
            if (li == 4'(pbl_pkg::NLOGS - 1)) begin
              state <= B_DIFF;
            end else begin
              li    <= li + 4'd1;
              state <= B_LOG;
            end
          end
        end
        B_DIFF: begin
          d[0]   <= $signed(DFW'(lg[0]) + DFW'(lg[8]) - DFW'(lg[5]) - DFW'(lg[7]));
          d[1]   <= $signed(DFW'(lg[3]) + DFW'(lg[8]) - DFW'(lg[4]) - DFW'(lg[6]));
          d[2]   <= $signed(DFW'(lg[1]) + DFW'(lg[8]) - DFW'(lg[5]) - DFW'(lg[6]));
          d[3]   <= $signed(DFW'(lg[2]) + DFW'(lg[8]) - DFW'(lg[4]) - DFW'(lg[7]));
          tv[0]  <= (vals[0] != '0) && (vals[5] != '0) && (vals[7] != '0);
          tv[1]  <= (vals[3] != '0) && (vals[4] != '0) && (vals[6] != '0);
          tv[2]  <= (vals[1] != '0) && (vals[5] != '0) && (vals[6] != '0);
          tv[3]  <= (vals[2] != '0) && (vals[4] != '0) && (vals[7] != '0);
          s_same <= '0;
          s_diff <= '0;
          ti     <= 2'd0;
          state  <= B_MUL;
        end
        B_MUL: begin
          prod  <= tv[ti] ? {{(SW - 48){mp[47]}}, mp} : '0;
          state <= B_ACC;
        end
        B_ACC: begin
          if (!ti[1]) begin
            s_same <= s_same + prod;
          end else begin
            s_diff <= s_diff + prod;
          end
          if (ti == 2'd3) begin
            di    <= 2'd0;
            state <= B_DIV;
          end else begin
            ti    <= ti + 2'd1;
            state <= B_MUL;
          end
        end
        B_DIV: state <= B_DIVW;
        B_DIVW: begin
          if (div_rsp.done) begin
            case (di)
              2'd0:    r_mi   <= div_rsp.value;
              2'd1:    r_same <= div_rsp.value;
              default: r_diff <= div_rsp.value;
            endcase
            if (di == 2'd2) begin
              state <= B_OUT;
            end else begin
              di    <= di + 2'd1;
              state <= B_DIV;
            end
          end
        end
        B_OUT: begin
          if (load_out) begin
            out_valid <= 1'b1;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      link_same   <= mode ? r_mi : r_same;
      link_diff   <= mode ? r_mi : r_diff;
      mutual_info <= r_mi;
      status      <= r_status;
    end
  end

endmodule

/* hdl/pairwise_bit_linkage_mi.sv */
// ----------------------------------------------------------------------------
// pairwise_bit_linkage_mi
// Pairwise bit-linkage statistics: clear, load bit-string rows, query the
// same-value, different-value and mutual-information linkage of two loci.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  in        in_valid / in_stall     kind, row_bits, locus_a, locus_b
//  out       out_valid / out_stall   link_same, link_diff, mutual_info, status
//  config    cfg_write               cfg_data (linkage_mode)
//
//  A load walks the locus counts then every locus pair, one store entry
//  per cycle. A query on two distinct loci with rows loaded runs nine logs
//  and three divides. After reset and on clear, a sweep over every entry
//  of both stores zeroes them; input is stalled while it runs.
//  Up to two items queue ahead of the sequencer; a stalled result holds it.
// ----------------------------------------------------------------------------
module pairwise_bit_linkage_mi #(
  parameter int LOCI      = pbl_pkg::LOCI_DEF,
  parameter int MAX_ROWS  = pbl_pkg::MAX_ROWS_DEF,
  parameter int FRAC_BITS = pbl_pkg::FRAC_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic                      cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                kind,
  input  logic [pbl_pkg::ROW_W-1:0] row_bits,
  input  logic [pbl_pkg::LOC_W-1:0] locus_a,
  input  logic [pbl_pkg::LOC_W-1:0] locus_b,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [pbl_pkg::OUT_W-1:0] link_same,
  output logic signed [pbl_pkg::OUT_W-1:0] link_diff,
  output logic signed [pbl_pkg::OUT_W-1:0] mutual_info,
  output logic [1:0]                status
);

  logic              mode;
  logic              q_valid;
  pbl_pkg::item_t    q_item;
  logic              q_pop;
  logic              init_busy;
  pbl_pkg::log_req_t log_req;
  pbl_pkg::log_rsp_t log_rsp;
  pbl_pkg::div_req_t div_req;
  pbl_pkg::div_rsp_t div_rsp;
  logic [pbl_pkg::OUT_W-1:0] same_u;
  logic [pbl_pkg::OUT_W-1:0] diff_u;
  logic [pbl_pkg::OUT_W-1:0] mi_u;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_write) begin
      mode <= cfg_data;
    end
  end

  pbl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .row_bits (row_bits),
    .locus_a  (locus_a),
    .locus_b  (locus_b),
    .hold     (init_busy),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  pbl_log u_log (
    .clk (clk),
    .rst (rst),
    .req (log_req),
    .rsp (log_rsp)
  );

  pbl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  pbl_back #(
    .LOCI      (LOCI),
    .MAX_ROWS  (MAX_ROWS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .mode        (mode),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .init_busy   (init_busy),
    .log_req     (log_req),
    .log_rsp     (log_rsp),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .link_same   (same_u),
    .link_diff   (diff_u),
    .mutual_info (mi_u),
    .status      (status)
  );

  assign link_same   = $signed(same_u);
  assign link_diff   = $signed(diff_u);
  assign mutual_info = $signed(mi_u);

endmodule

/* tb/sv/pbl_checker.sv */
// ----------------------------------------------------------------------------
// pbl_checker
// Watches the item and result channels of the pairwise bit-linkage block,
// keeps its own copy of the row counts and predicts every query result in
// fixed point, then compares each accepted result field by field.
// ----------------------------------------------------------------------------
module pbl_checker
  import pbl_pkg::*;
#(
  parameter int LOCI      = LOCI_DEF,
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic                    cfg_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [1:0]              kind,
  input  logic [ROW_W-1:0]        row_bits,
  input  logic [LOC_W-1:0]        locus_a,
  input  logic [LOC_W-1:0]        locus_b,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [OUT_W-1:0] link_same,
  input  logic signed [OUT_W-1:0] link_diff,
  input  logic signed [OUT_W-1:0] mutual_info,
  input  logic [1:0]              status,
  output int                      fail_count,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [OUT_W-1:0] same;
    logic [OUT_W-1:0] diff;
    logic [OUT_W-1:0] mi;
    logic [1:0]       st;
  } linkage_t;

  linkage_t   expected_q[$];
  int         rows_n;
  int         ones_n[64];
  int         both_n[64][64];
  logic       mode_mi;

  assign pending = expected_q.size();

  function automatic longint unsigned log_nat_q30(int k);
    int unsigned e;
    longint unsigned m, frac;
    e = 0;
    frac = 0;
    k = k & 'h7ff;
    if (k == 0) return 0;
    while ((k >> e) > 1) e++;
    m = longint'(k) << (30 - e);
    for (int s = 0; s < 30; s++) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac |= 64'd1 << (29 - s);
      end
    end
    return (((longint'(e) << 30) + frac) * 64'd744261118 + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint cell_info(int n, int ra, int rb, int tot);
    longint d;
    if (n == 0 || ra == 0 || rb == 0 || tot == 0) return 0;
    d = longint'(log_nat_q30(n) + log_nat_q30(tot))
        - longint'(log_nat_q30(ra) + log_nat_q30(rb));
    return longint'(n) * d;
  endfunction

  function automatic logic [OUT_W-1:0] scale_q(longint s, int tot);
    longint unsigned den, mag, q;
    den = longint'(tot) << (30 - FRAC_BITS);
    if (den == 0) return '0;
    mag = (s < 0) ? -s : s;
    q = (mag + den / 2) / den;
    if (s < 0) begin
      if (q > (64'd1 << 23)) q = 64'd1 << 23;
      return OUT_W'(-q);
    end
    if (q > (64'd1 << 23) - 1) q = (64'd1 << 23) - 1;
    return OUT_W'(q);
  endfunction

  function automatic linkage_t predict_linkage(int la, int lb);
    linkage_t r;
    int a, b, na, nb, n11, n10, n01, n00;
    longint ss, sd;
    r = '0;
    a = (la < lb) ? la : lb;
    b = (la < lb) ? lb : la;
    if (a == b) begin
      r.st = ST_SAME;
      return r;
    end
    if (rows_n == 0) begin
      r.st = ST_EMPTY;
      return r;
    end
    r.st = ST_OK;
    na = (a < LOCI) ? ones_n[a] : 0;
    nb = (b < LOCI) ? ones_n[b] : 0;
    n11 = (b < LOCI) ? both_n[a][b] : 0;
    if (n11 > na) n11 = na;
    if (n11 > nb) n11 = nb;
    n10 = na - n11;
    n01 = nb - n11;
    n00 = (rows_n >= na + n01) ? rows_n - na - n01 : 0;
    ss = cell_info(n00, rows_n - na, rows_n - nb, rows_n) + cell_info(n11, na, nb, rows_n);
    sd = cell_info(n01, rows_n - na, nb, rows_n) + cell_info(n10, na, rows_n - nb, rows_n);
    r.mi = scale_q(ss + sd, rows_n);
    r.same = mode_mi ? r.mi : scale_q(ss, rows_n);
    r.diff = mode_mi ? r.mi : scale_q(sd, rows_n);
    return r;
  endfunction

  task automatic report(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
    $display("%0t: %s got %h want %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    linkage_t w;
    if (rst) begin
      rows_n <= 0;
      foreach (ones_n[i]) ones_n[i] <= 0;
      foreach (both_n[i, j]) both_n[i][j] <= 0;
      mode_mi <= 1'b0;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_write) mode_mi = cfg_data;
      if (in_valid && !in_stall) begin
        case (kind)
          KIND_CLEAR: begin
            rows_n = 0;
            foreach (ones_n[i]) ones_n[i] = 0;
            foreach (both_n[i, j]) both_n[i][j] = 0;
          end
          KIND_LOAD: begin
            if (rows_n < MAX_ROWS) begin
              rows_n++;
              for (int i = 0; i < LOCI; i++) begin
                if (row_bits[i]) begin
                  ones_n[i]++;
                  for (int j = i + 1; j < LOCI; j++)
                    if (row_bits[j]) both_n[i][j]++;
                end
              end
            end
          end
          KIND_QUERY: expected_q = {expected_q, predict_linkage(locus_a, locus_b)};
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", OUT_W'(status), '0);
        end else begin
          w = expected_q.pop_front();
          if (status !== w.st) report("status", OUT_W'(status), OUT_W'(w.st));
          if (link_same !== w.same) report("link_same", link_same, w.same);
          if (link_diff !== w.diff) report("link_diff", link_diff, w.diff);
          if (mutual_info !== w.mi) report("mutual_info", mutual_info, w.mi);
        end
      end
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives clears, row loads and pair queries into the pairwise bit-linkage
// block in both linkage modes with random idle and stall, and reports the
// verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import pbl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 60000;
  localparam int DRAIN_CYCLES = 7000;

  logic                    clk;
  logic                    rst;
  logic                    cfg_write;
  logic                    cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              kind;
  logic [ROW_W-1:0]        row_bits;
  logic [LOC_W-1:0]        locus_a;
  logic [LOC_W-1:0]        locus_b;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [OUT_W-1:0] link_same;
  logic signed [OUT_W-1:0] link_diff;
  logic signed [OUT_W-1:0] mutual_info;
  logic [1:0]              status;
  int                      fail_count;
  int                      pending;
  int                      quiet_cycles;
  bit                      steady;

  pairwise_bit_linkage_mi i_dut (.*);
  pbl_checker i_checker (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    out_stall <= (!steady && $urandom_range(99) < 28);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_item(logic [1:0] k, logic [ROW_W-1:0] r, int a, int b);
    while (!steady && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    row_bits <= r;
    locus_a  <= LOC_W'(a);
    locus_b  <= LOC_W'(b);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic set_mode(logic m);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [ROW_W-1:0] rand_row();
    logic [ROW_W-1:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(3))
      0: r = r & {$urandom, $urandom};
      1: r = r | {$urandom, $urandom};
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    kind = KIND_CLEAR;
    row_bits = '0;
    locus_a = '0;
    locus_b = '0;
    steady = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(KIND_QUERY, '0, 3, 9);
    send_item(KIND_QUERY, '0, 5, 5);
    send_item(KIND_LOAD, '1, 0, 0);
    send_item(KIND_LOAD, '0, 0, 0);
    send_item(KIND_LOAD, 64'haaaa_aaaa_aaaa_aaaa, 0, 0);
    send_item(KIND_LOAD, 64'h5555_5555_5555_5555, 0, 0);
    send_item(KIND_QUERY, '0, 0, 63);
    send_item(KIND_QUERY, '0, 63, 0);
    send_item(KIND_QUERY, '0, 1, 3);
    send_item(KIND_QUERY, '0, 63, 63);
    send_item(2'd3, '1, 1, 2);
    send_item(KIND_QUERY, '0, 62, 61);
    set_mode(1'b1);
    send_item(KIND_QUERY, '0, 0, 1);
    send_item(KIND_QUERY, '0, 2, 4);
    send_item(KIND_CLEAR, '1, 0, 0);
    send_item(KIND_QUERY, '0, 0, 1);
    set_mode(1'b0);

    for (int phase = 0; phase < 4; phase++) begin
      steady = (phase == 2);
      for (int n = 0; n < 65; n++) begin
        case ($urandom_range(19))
          0: send_item(KIND_CLEAR, rand_row(), $urandom_range(63), $urandom_range(63));
          1: send_item(2'd3, rand_row(), $urandom_range(63), $urandom_range(63));
          2, 3, 4, 5, 6, 7, 8, 9, 10:
            send_item(KIND_LOAD, rand_row(), $urandom_range(63), $urandom_range(63));
          default:
            send_item(KIND_QUERY, rand_row(), $urandom_range(63),
                      ($urandom_range(9) == 0) ? -1 : $urandom_range(63));
        endcase
      end
      set_mode(phase[0] ? 1'b0 : 1'b1);
    end
    steady = 1'b0;

    send_item(KIND_QUERY, '0, 0, 1);
    send_item(KIND_QUERY, '0, 40, 7);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
